// ----- src/dmsc_pkg.sv -----
// shared types and constants of the direct-mapped sector cache
`default_nettype none

package dmsc_pkg;

  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned SECTOR_W   = 32;
  localparam int unsigned WORD_IDX_W = 6;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned BE_W       = 8;
  localparam int unsigned STATUS_W   = 2;

  // request codes; code 7 is unused and acknowledged without effect
  typedef enum logic [TYPE_W-1:0] {
    REQ_READ       = 3'd0,
    REQ_WRITE      = 3'd1,
    REQ_INSTALL    = 3'd2,
    REQ_FILL       = 3'd3,
    REQ_INVALIDATE = 3'd4,
    REQ_FLUSH      = 3'd5,
    REQ_PREFETCH   = 3'd6
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_READ_DATA  = 2'd0,
    STS_ACK        = 2'd1,
    STS_MISS       = 2'd2,
    STS_WRITE_BACK = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR  = 2'd0,
    FSM_IDLE   = 2'd1,
    FSM_LOOKUP = 2'd2,
    FSM_EVICT  = 2'd3
  } fsm_e;

  // one slot of the tag memory
  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [SECTOR_W-1:0] tag;
  } meta_t;

  typedef struct packed {
    status_e               status;
    logic [SECTOR_W-1:0]   sector;
    logic [WORD_IDX_W-1:0] word;
    logic [DATA_W-1:0]     rdata;
    logic                  last;
    logic                  fetch;
    logic [SECTOR_W-1:0]   fetch_sector;
  } result_t;

endpackage

`default_nettype wire

// ----- src/dmsc_slot_map.sv -----
// maps a sector number to its slot and a word index to its word within the sector
`default_nettype none

module dmsc_slot_map #(
  parameter int unsigned ENTRIES      = 64,
  parameter int unsigned SECTOR_WORDS = 64,
  localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned WORD_W = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1
) (
  input  logic [dmsc_pkg::SECTOR_W-1:0]   sector_i,
  input  logic [dmsc_pkg::WORD_IDX_W-1:0] word_index_i,
  output logic [SLOT_W-1:0]               slot_o,
  output logic [WORD_W-1:0]               word_o
);
  import dmsc_pkg::*;

  localparam int unsigned SUM_W = SLOT_W + 2;
  localparam logic [SUM_W-1:0] ONE_E = SUM_W'(ENTRIES);
  localparam logic [SUM_W-1:0] TWO_E = SUM_W'(2 * ENTRIES);

  // residue of each byte lane weighted by its position, mod entries
  logic [SLOT_W-1:0] res_rom [4][256];
  logic [WORD_W-1:0] word_rom [1 << WORD_IDX_W];
  logic [SLOT_W-1:0] byte_res [4];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  red;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    for (genvar b = 0; b < 256; b++) begin : g_ent
      assign res_rom[k][b] =
        SLOT_W'(((b % ENTRIES) * ((1 << (8 * k)) % ENTRIES)) % ENTRIES);
    end
  end

  for (genvar g = 0; g < (1 << WORD_IDX_W); g++) begin : g_word
    assign word_rom[g] = WORD_W'(g % SECTOR_WORDS);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_res[k] = res_rom[k][sector_i[8*k +: 8]];
    end
    sum = SUM_W'(byte_res[0]) + SUM_W'(byte_res[1]) +
          SUM_W'(byte_res[2]) + SUM_W'(byte_res[3]);
    // sum stays below four times entries
    red = (sum >= TWO_E) ? (sum - TWO_E) : sum;
    red = (red >= ONE_E) ? (red - ONE_E) : red;
  end

  assign slot_o = SLOT_W'(red);
  assign word_o = word_rom[word_index_i];

endmodule

`default_nettype wire

// ----- src/direct_mapped_sector_cache.sv -----
// direct-mapped write-back cache of disk sectors with tag and data memories
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+---------------------------------
//   request   | in        | start high while busy is low | req_type, sector, word_index,
//             |           |                              | wdata, byte_enable
//   result    | out       | result_valid_o for one cycle | status, out_sector, out_word,
//             |           |                              | rdata, last, fetch, fetch_sector
//
// a request without eviction reads the tag and data memories in the accept cycle
// and makes its decision in the lookup cycle; its result is registered and shows in
// the cycle after the lookup. a request that evicts a dirty victim streams
// min(SECTOR_WORDS, 64) stored words, one per cycle, through the single read
// port of the data memory. after reset busy stays high while a clearing pass
// zeroes the tag memory. results cannot be stalled: each is on the ports for
// exactly one cycle.
`default_nettype none

module direct_mapped_sector_cache #(
  parameter int unsigned ENTRIES      = 64,
  parameter int unsigned SECTOR_WORDS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [dmsc_pkg::TYPE_W-1:0]       req_type_i,
  input  logic [dmsc_pkg::SECTOR_W-1:0]     sector_i,
  input  logic [dmsc_pkg::WORD_IDX_W-1:0]   word_index_i,
  input  logic [dmsc_pkg::DATA_W-1:0]       wdata_i,
  input  logic [dmsc_pkg::BE_W-1:0]         byte_enable_i,
  output logic                              result_valid_o,
  output logic [dmsc_pkg::STATUS_W-1:0]     status_o,
  output logic [dmsc_pkg::SECTOR_W-1:0]     out_sector_o,
  output logic [dmsc_pkg::WORD_IDX_W-1:0]   out_word_o,
  output logic [dmsc_pkg::DATA_W-1:0]       rdata_o,
  output logic                              last_o,
  output logic                              fetch_o,
  output logic [dmsc_pkg::SECTOR_W-1:0]     fetch_sector_o
);
  import dmsc_pkg::*;

  localparam int unsigned SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WORD_W     = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
  localparam int unsigned ADDR_W     = SLOT_W + WORD_W;
  localparam int unsigned DATA_DEPTH = 1 << ADDR_W;
  // a victim streams at most 64 words, the reach of out_word
  localparam int unsigned EV_N       = (SECTOR_WORDS < 64) ? SECTOR_WORDS : 64;
  localparam logic [WORD_IDX_W-1:0] EV_LAST  = WORD_IDX_W'(EV_N - 1);
  localparam logic [SLOT_W-1:0]     CLR_LAST = SLOT_W'(ENTRIES - 1);

  // control state
  fsm_e                  state_q, state_d;
  logic [SLOT_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [WORD_IDX_W-1:0] ev_cnt_q, ev_cnt_d;

  // captured request
  logic [TYPE_W-1:0]     type_q;
  logic [SECTOR_W-1:0]   sector_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [WORD_W-1:0]     word_q;
  logic [DATA_W-1:0]     wdata_q;
  logic [BE_W-1:0]       be_q;

  logic [SLOT_W-1:0]     slot_w;
  logic [WORD_W-1:0]     word_w;
  logic                  accept;

  // memories
  meta_t                 meta_mem [ENTRIES];
  meta_t                 meta_rd_q;
  logic                  meta_we, meta_re;
  logic [SLOT_W-1:0]     meta_waddr, meta_raddr;
  meta_t                 meta_wdata;

  logic [DATA_W-1:0]     data_mem [DATA_DEPTH];
  logic [DATA_W-1:0]     data_rd_q;
  logic                  data_we, data_re;
  logic [ADDR_W-1:0]     data_waddr, data_raddr;
  logic [DATA_W-1:0]     data_wdata;

  // result register
  logic                  res_valid_q, res_valid_d;
  result_t               res_q, res_d;

  // lookup decisions
  logic                  hit;
  logic                  victim_dirty;
  logic                  need_evict;
  logic                  ev_last;
  logic                  ev_fetch;
  logic [DATA_W-1:0]     be_mask;
  logic [DATA_W-1:0]     merged;
  result_t               ack;

  dmsc_slot_map #(
    .ENTRIES      (ENTRIES),
    .SECTOR_WORDS (SECTOR_WORDS)
  ) u_slot_map (
    .sector_i     (sector_i),
    .word_index_i (word_index_i),
    .slot_o       (slot_w),
    .word_o       (word_w)
  );

  assign busy   = (state_q != FSM_IDLE);
  assign accept = start && !busy;

  // tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_q <= meta_mem[meta_raddr];
    end
  end

  // data memory, registered read
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (data_re) begin
      data_rd_q <= data_mem[data_raddr];
    end
  end

  // request capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q   <= req_type_i;
      sector_q <= sector_i;
      slot_q   <= slot_w;
      word_q   <= word_w;
      wdata_q  <= wdata_i;
      be_q     <= byte_enable_i;
    end
  end

  // hit and victim checks against the slot read in the accept cycle
  assign hit          = meta_rd_q.valid && (meta_rd_q.tag == sector_q);
  assign victim_dirty = meta_rd_q.valid && meta_rd_q.dirty;
  assign ev_fetch     = (type_q == REQ_READ) || (type_q == REQ_PREFETCH);
  assign ev_last      = (ev_cnt_q == EV_LAST);

  always_comb begin
    need_evict = 1'b0;
    case (type_q)
      REQ_READ, REQ_PREFETCH, REQ_INSTALL: need_evict = !hit && victim_dirty;
      REQ_FLUSH:                           need_evict = victim_dirty;
      default:                             need_evict = 1'b0;
    endcase
  end

  // byte-enable merge for writes
  always_comb begin
    for (int b = 0; b < BE_W; b++) begin
      be_mask[8*b +: 8] = {8{be_q[b]}};
    end
    merged = (data_rd_q & ~be_mask) | (wdata_q & be_mask);
  end

  always_comb begin
    ack              = '0;
    ack.status       = STS_ACK;
    ack.sector       = sector_q;
    ack.word         = WORD_IDX_W'(word_q);
    ack.last         = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (accept) state_d = FSM_LOOKUP;
      end
      FSM_LOOKUP: begin
        state_d = need_evict ? FSM_EVICT : FSM_IDLE;
      end
      FSM_EVICT: begin
        if (ev_last) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // memory controls, counters and results
  always_comb begin
    meta_we     = 1'b0;
    meta_waddr  = slot_q;
    meta_wdata  = '0;
    meta_re     = 1'b0;
    meta_raddr  = slot_w;
    data_we     = 1'b0;
    data_waddr  = {slot_q, word_q};
    data_wdata  = wdata_q;
    data_re     = 1'b0;
    data_raddr  = {slot_w, word_w};
    clr_cnt_d   = clr_cnt_q;
    ev_cnt_d    = ev_cnt_q;
    res_valid_d = 1'b0;
    res_d       = ack;

    case (state_q)
      FSM_CLEAR: begin
        // zero one slot per cycle
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_q;
        clr_cnt_d  = clr_cnt_q + SLOT_W'(1);
      end

      FSM_IDLE: begin
        meta_re = accept;
        data_re = accept;
      end

      FSM_LOOKUP: begin
        if (need_evict) begin
          // first victim word, streaming starts next cycle
          data_re    = 1'b1;
          data_raddr = {slot_q, WORD_W'(0)};
          ev_cnt_d   = '0;
        end else begin
          res_valid_d = 1'b1;
          case (type_q)
            REQ_READ, REQ_PREFETCH: begin
              if (hit) begin
                if (type_q == REQ_READ) begin
                  res_d.status = STS_READ_DATA;
                  res_d.rdata  = data_rd_q;
                end
              end else begin
                // claim the slot now, host fills it afterwards
                meta_we            = 1'b1;
                meta_wdata         = '{valid: 1'b1, dirty: 1'b0, tag: sector_q};
                res_d.status       = STS_MISS;
                res_d.fetch        = 1'b1;
                res_d.fetch_sector = sector_q;
              end
            end
            REQ_WRITE: begin
              if (!hit) begin
                res_d.status = STS_MISS;
              end else if (merged != data_rd_q) begin
                // dirty only when the word really changes
                data_we    = 1'b1;
                data_wdata = merged;
                meta_we    = 1'b1;
                meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: sector_q};
              end
            end
            REQ_FILL: begin
              if (!hit) begin
                res_d.status = STS_MISS;
              end else begin
                data_we = 1'b1;
              end
            end
            REQ_INSTALL: begin
              data_we    = 1'b1;
              meta_we    = 1'b1;
              meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: sector_q};
            end
            REQ_INVALIDATE: begin
              if (hit) begin
                meta_we    = 1'b1;
                meta_wdata = '{valid: 1'b0, dirty: 1'b0, tag: meta_rd_q.tag};
              end
            end
            default: ; // clean flush and unused code: plain acknowledge
          endcase
        end
      end

      FSM_EVICT: begin
        // emit word ev_cnt_q, read the one after it
        data_re            = 1'b1;
        data_raddr         = {slot_q, WORD_W'(ev_cnt_q + WORD_IDX_W'(1))};
        ev_cnt_d           = ev_cnt_q + WORD_IDX_W'(1);
        res_valid_d        = 1'b1;
        res_d.status       = STS_WRITE_BACK;
        res_d.sector       = meta_rd_q.tag;
        res_d.word         = ev_cnt_q;
        res_d.rdata        = data_rd_q;
        res_d.last         = ev_last;
        res_d.fetch        = ev_last && ev_fetch;
        res_d.fetch_sector = (ev_last && ev_fetch) ? sector_q : '0;
        if (ev_last) begin
          meta_we = 1'b1;
          case (type_q)
            REQ_READ, REQ_PREFETCH: begin
              meta_wdata = '{valid: 1'b1, dirty: 1'b0, tag: sector_q};
            end
            REQ_INSTALL: begin
              // victim fully read, now store the installed word
              meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: sector_q};
              data_we    = 1'b1;
            end
            default: begin
              // flush keeps the slot valid and clean
              meta_wdata = '{valid: 1'b1, dirty: 1'b0, tag: meta_rd_q.tag};
            end
          endcase
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_CLEAR;
      clr_cnt_q   <= '0;
      ev_cnt_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ev_cnt_q    <= ev_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_q.status;
  assign out_sector_o   = res_q.sector;
  assign out_word_o     = res_q.word;
  assign rdata_o        = res_q.rdata;
  assign last_o         = res_q.last;
  assign fetch_o        = res_q.fetch;
  assign fetch_sector_o = res_q.fetch_sector;

endmodule

`default_nettype wire

// ----- verif/direct_mapped_sector_cache_tb.sv -----
// self-checking testbench of the direct-mapped sector cache
`timescale 1ns / 1ps

module direct_mapped_sector_cache_tb;
  import dmsc_pkg::*;

  localparam int unsigned SLOTS        = 64;
  localparam int unsigned WORDS        = 64;
  localparam int unsigned ITEM_TARGET  = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;
  // code 7 is not a request type; the block acknowledges it and changes nothing
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [TYPE_W-1:0]     req_type_i;
  logic [SECTOR_W-1:0]   sector_i;
  logic [WORD_IDX_W-1:0] word_index_i;
  logic [DATA_W-1:0]     wdata_i;
  logic [BE_W-1:0]       byte_enable_i;
  logic                  result_valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SECTOR_W-1:0]   out_sector_o;
  logic [WORD_IDX_W-1:0] out_word_o;
  logic [DATA_W-1:0]     rdata_o;
  logic                  last_o;
  logic                  fetch_o;
  logic [SECTOR_W-1:0]   fetch_sector_o;

  direct_mapped_sector_cache #(
    .ENTRIES      (SLOTS),
    .SECTOR_WORDS (WORDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .sector_i       (sector_i),
    .word_index_i   (word_index_i),
    .wdata_i        (wdata_i),
    .byte_enable_i  (byte_enable_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_sector_o   (out_sector_o),
    .out_word_o     (out_word_o),
    .rdata_o        (rdata_o),
    .last_o         (last_o),
    .fetch_o        (fetch_o),
    .fetch_sector_o (fetch_sector_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // shadow copy of the cache contents, updated at each accepted request
  logic                shadow_valid [SLOTS];
  logic                shadow_dirty [SLOTS];
  logic [SECTOR_W-1:0] shadow_tag   [SLOTS];
  logic [DATA_W-1:0]   shadow_data  [SLOTS*WORDS];
  // every word of the slot has been written at least once, so reading it is legal
  bit                  slot_loaded  [SLOTS];

  result_t     expected_results [$];
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned writebacks_seen;
  int unsigned fetches_seen;
  int unsigned mismatches;
  bit          idle_enable;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void push_result(status_e st, logic [SECTOR_W-1:0] sec,
                                      logic [WORD_IDX_W-1:0] word, logic [DATA_W-1:0] data,
                                      logic fin, logic fch, logic [SECTOR_W-1:0] fsec);
    result_t r;
    r.status       = st;
    r.sector       = sec;
    r.word         = word;
    r.rdata        = data;
    r.last         = fin;
    r.fetch        = fch;
    r.fetch_sector = fch ? fsec : '0;
    expected_results.push_back(r);
  endfunction

  // streams a dirty victim word by word; the final word carries last and maybe fetch
  function automatic int write_back_slot(logic [5:0] slot, logic fch,
                                         logic [SECTOR_W-1:0] fsec);
    int i;
    if (!(shadow_valid[slot] && shadow_dirty[slot])) return 0;
    for (i = 0; i < WORDS; i++) begin
      push_result(STS_WRITE_BACK, shadow_tag[slot], i[5:0], shadow_data[slot*WORDS+i],
                  i == WORDS - 1, (i == WORDS - 1) && fch, fsec);
    end
    shadow_dirty[slot] = 1'b0;
    return WORDS;
  endfunction

  function automatic void predict_request(logic [TYPE_W-1:0] kind,
                                          logic [SECTOR_W-1:0] sector,
                                          logic [WORD_IDX_W-1:0] word,
                                          logic [DATA_W-1:0] wdata, logic [BE_W-1:0] be);
    logic [5:0]        slot;
    int unsigned       idx;
    logic              hit;
    int                n;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] merged;
    slot = sector[5:0];
    idx  = slot * WORDS + word;
    hit  = shadow_valid[slot] && shadow_tag[slot] == sector;
    case (kind)
      REQ_READ, REQ_PREFETCH: begin
        if (hit) begin
          if (kind == REQ_READ)
            push_result(STS_READ_DATA, sector, word, shadow_data[idx], 1'b1, 1'b0, '0);
          else
            push_result(STS_ACK, sector, word, '0, 1'b1, 1'b0, '0);
        end else begin
          // the slot is claimed at once; the fill words follow from the host
          n = write_back_slot(slot, 1'b1, sector);
          shadow_valid[slot] = 1'b1;
          shadow_dirty[slot] = 1'b0;
          shadow_tag[slot]   = sector;
          if (n == 0) push_result(STS_MISS, sector, word, '0, 1'b1, 1'b1, sector);
        end
      end
      REQ_WRITE, REQ_FILL: begin
        if (!hit) begin
          push_result(STS_MISS, sector, word, '0, 1'b1, 1'b0, '0);
        end else begin
          if (kind == REQ_FILL) begin
            shadow_data[idx] = wdata;
          end else begin
            for (int b = 0; b < BE_W; b++) mask[8*b +: 8] = {8{be[b]}};
            merged = (shadow_data[idx] & ~mask) | (wdata & mask);
            // only a real change of the word makes the slot dirty
            if (merged != shadow_data[idx]) begin
              shadow_data[idx]   = merged;
              shadow_dirty[slot] = 1'b1;
            end
          end
          push_result(STS_ACK, sector, word, '0, 1'b1, 1'b0, '0);
        end
      end
      REQ_INSTALL: begin
        n = 0;
        if (!hit) begin
          n = write_back_slot(slot, 1'b0, '0);
          shadow_valid[slot] = 1'b1;
          shadow_tag[slot]   = sector;
        end
        shadow_dirty[slot] = 1'b1;
        shadow_data[idx]   = wdata;
        // the last write-back word doubles as the acknowledge
        if (n == 0) push_result(STS_ACK, sector, word, '0, 1'b1, 1'b0, '0);
      end
      REQ_INVALIDATE: begin
        if (hit) begin
          shadow_valid[slot] = 1'b0;
          shadow_dirty[slot] = 1'b0;
        end
        push_result(STS_ACK, sector, word, '0, 1'b1, 1'b0, '0);
      end
      REQ_FLUSH: begin
        n = write_back_slot(slot, 1'b0, '0);
        if (n == 0) push_result(STS_ACK, sector, word, '0, 1'b1, 1'b0, '0);
      end
      default: begin
        push_result(STS_ACK, sector, word, '0, 1'b1, 1'b0, '0);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // drives one request from a falling edge and holds it until accepted
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [SECTOR_W-1:0] sector,
                              logic [WORD_IDX_W-1:0] word, logic [DATA_W-1:0] wdata,
                              logic [BE_W-1:0] be);
    @(negedge clk_i);
    if (idle_enable && $urandom_range(99) < 14) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start         = 1'b1;
    req_type_i    = kind;
    sector_i      = sector;
    word_index_i  = word;
    wdata_i       = wdata;
    byte_enable_i = be;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(kind, sector, word, wdata, be);
    requests_sent++;
  endtask

  // data with the all-zero and all-one words showing up often
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // a whole sector, word 0 to 63, as fill or install requests
  task automatic load_sector_run(logic [TYPE_W-1:0] kind, logic [SECTOR_W-1:0] sector);
    for (int w = 0; w < WORDS; w++)
      send_request(kind, sector, w[5:0], random_word(), BE_W'($urandom));
    slot_loaded[sector[5:0]] = 1'b1;
  endtask

  // a few hot slots and a few tags per slot, so hits and conflicts both happen
  function automatic logic [SECTOR_W-1:0] pick_sector();
    logic [5:0]  slot;
    logic [25:0] upper;
    case ($urandom_range(9))
      0:       slot = 6'd63;
      1, 2:    slot = 6'($urandom_range(63));
      default: slot = 6'($urandom_range(7));
    endcase
    case ($urandom_range(9))
      0, 1, 2: upper = 26'd0;
      3, 4:    upper = 26'd1;
      5, 6:    upper = 26'd2;
      7:       upper = '1;
      default: upper = 26'($urandom);
    endcase
    return {upper, slot};
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // requests that meet no valid slot and change nothing
  task automatic test_empty_cache();
    send_request(REQ_WRITE, 32'h0000_0000, 6'd0, '1, 8'hFF);
    send_request(REQ_FILL, 32'hFFFF_FFFF, 6'd63, '0, 8'h00);
    send_request(REQ_INVALIDATE, 32'h0000_0005, 6'd1, '0, 8'h00);
    send_request(REQ_FLUSH, 32'h0000_0007, 6'd2, '0, 8'h00);
    send_request(REQ_UNUSED, 32'hDEAD_BEEF, 6'd42, '1, 8'hFF);
  endtask

  // read miss asks for a fetch, the fill run completes the slot, then hits
  task automatic test_fetch_and_fill();
    send_request(REQ_READ, 32'h0000_0000, 6'd63, '0, 8'h00);
    load_sector_run(REQ_FILL, 32'h0000_0000);
    send_request(REQ_READ, 32'h0000_0000, 6'd0, '0, 8'h00);
    send_request(REQ_READ, 32'h0000_0000, 6'd63, '0, 8'h00);
    send_request(REQ_PREFETCH, 32'h0000_0000, 6'd17, '0, 8'h00);
  endtask

  // byte-enable merge and the dirty-only-on-change rule
  task automatic test_write_merge();
    send_request(REQ_WRITE, 32'h0000_0000, 6'd5, {$urandom, $urandom}, 8'h00);
    send_request(REQ_WRITE, 32'h0000_0000, 6'd6, shadow_data[6], 8'hFF);
    // still clean, so a flush only acknowledges
    send_request(REQ_FLUSH, 32'h0000_0000, 6'd0, '0, 8'h00);
    send_request(REQ_WRITE, 32'h0000_0000, 6'd7, ~shadow_data[7], 8'hA5);
    send_request(REQ_READ, 32'h0000_0000, 6'd7, '0, 8'h00);
    // flush picks the slot only, so another tag of slot 0 writes sector 0 back
    send_request(REQ_FLUSH, 32'h0000_0040, 6'd9, '0, 8'h00);
    send_request(REQ_FLUSH, 32'h0000_0000, 6'd9, '0, 8'h00);
  endtask

  // install run, prefetch over a dirty victim, install with and without eviction
  task automatic test_install_and_evict();
    load_sector_run(REQ_INSTALL, 32'hFFFF_FFFF);
    // conflicting prefetch streams the installed sector out with fetch on its end
    send_request(REQ_PREFETCH, 32'h0000_003F, 6'd9, '0, 8'h00);
    // the fill run goes back to back
    idle_enable = 1'b0;
    load_sector_run(REQ_FILL, 32'h0000_003F);
    idle_enable = 1'b1;
    // clean slot: install takes it over without write-back
    send_request(REQ_INSTALL, 32'h0000_0080, 6'd3, random_word(), 8'h00);
    // dirty slot: install evicts, the last write-back word is its acknowledge
    send_request(REQ_INSTALL, 32'h0000_0040, 6'd4, random_word(), 8'h00);
    send_request(REQ_READ, 32'h0000_0040, 6'd4, '0, 8'h00);
  endtask

  // invalidate drops a dirty slot silently
  task automatic test_invalidate();
    send_request(REQ_INVALIDATE, 32'h0000_0040, 6'd0, '0, 8'h00);
    send_request(REQ_INVALIDATE, 32'h0000_0040, 6'd0, '0, 8'h00);
    send_request(REQ_WRITE, 32'h0000_0040, 6'd1, '1, 8'hFF);
  endtask

  // mostly legal traffic over a small working set, with some noise
  task automatic test_random_traffic();
    logic [SECTOR_W-1:0]   sector;
    logic [5:0]            slot;
    logic [WORD_IDX_W-1:0] word;
    logic                  hit;
    int unsigned           pick;
    logic [BE_W-1:0]       be;
    logic [DATA_W-1:0]     wdata;
    while (requests_sent < ITEM_TARGET) begin
      sector = pick_sector();
      slot   = sector[5:0];
      word   = 6'($urandom_range(63));
      hit    = shadow_valid[slot] && shadow_tag[slot] == sector;
      pick   = $urandom_range(99);
      if (pick < 33) begin
        // a miss claims the slot, so the fill run must come next
        send_request(pick < 25 ? REQ_READ : REQ_PREFETCH, sector, word, random_word(),
                     BE_W'($urandom));
        if (!hit) load_sector_run(REQ_FILL, sector);
      end else if (pick < 53) begin
        case ($urandom_range(7))
          0:       be = '0;
          1:       be = '1;
          default: be = BE_W'($urandom);
        endcase
        // sometimes rewrite the stored value so nothing changes
        wdata = ($urandom_range(3) == 0) ? shadow_data[slot*WORDS+word] : random_word();
        send_request(REQ_WRITE, sector, word, wdata, be);
      end else if (pick < 65) begin
        // a lone install word is only legal once the slot was fully written
        if (!slot_loaded[slot] || $urandom_range(3) == 0)
          load_sector_run(REQ_INSTALL, sector);
        else
          send_request(REQ_INSTALL, sector, word, random_word(), BE_W'($urandom));
      end else if (pick < 70) begin
        send_request(REQ_FILL, sector, word, random_word(), BE_W'($urandom));
      end else if (pick < 82) begin
        send_request(REQ_INVALIDATE, sector, word, random_word(), BE_W'($urandom));
      end else if (pick < 95) begin
        send_request(REQ_FLUSH, sector, word, random_word(), BE_W'($urandom));
      end else if (pick < 97) begin
        send_request(REQ_UNUSED, sector, word, random_word(), BE_W'($urandom));
      end else begin
        // stray write or fill to an arbitrary sector
        send_request($urandom_range(1) ? REQ_WRITE : REQ_FILL, $urandom, word,
                     random_word(), BE_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (status_o == STS_WRITE_BACK) writebacks_seen++;
      if (fetch_o) fetches_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: st=%0d sec=%h word=%0d data=%h", $realtime,
                   status_o, out_sector_o, out_word_o, rdata_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || out_sector_o !== want.sector ||
            out_word_o !== want.word || rdata_o !== want.rdata || last_o !== want.last ||
            fetch_o !== want.fetch || fetch_sector_o !== want.fetch_sector) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: expected st=%0d sec=%h word=%0d data=%h last=%b",
                     $realtime, want.status, want.sector, want.word, want.rdata, want.last);
            $display("    fetch=%b fsec=%h | got st=%0d sec=%h word=%0d data=%h last=%b",
                     want.fetch, want.fetch_sector, status_o, out_sector_o, out_word_o,
                     rdata_o, last_o);
            $display("    fetch=%b fsec=%h", fetch_o, fetch_sector_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_type_i    = REQ_READ;
    sector_i      = '0;
    word_index_i  = '0;
    wdata_i       = '0;
    byte_enable_i = '0;
    idle_enable   = 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_dirty[s] = 1'b0;
      shadow_tag[s]   = '0;
      slot_loaded[s]  = 1'b0;
    end
    for (int d = 0; d < SLOTS * WORDS; d++) shadow_data[d] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // the clearing pass after reset keeps busy high; send_request waits it out
    test_empty_cache();
    test_fetch_and_fill();
    test_write_merge();
    test_install_and_evict();
    test_invalidate();
    test_random_traffic();

    @(negedge clk_i);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // a late eviction stream would show up within this window
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests and %0d results", requests_sent, results_seen);
    $display("%0d write-back words, %0d fetches, %0d mismatches",
             writebacks_seen, fetches_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- direct_mapped_sector_cache.f -----
src/dmsc_pkg.sv
src/dmsc_slot_map.sv
src/direct_mapped_sector_cache.sv
verif/direct_mapped_sector_cache_tb.sv
